// ===== rtl/stereo_chorus_delay_assert.svh =====
// ---------------------------------------------------------------------------
// Stereo chorus delay: assertion macros
// Shared property macros for the chorus modules. They expect clk and rst_n
// in scope and compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef STEREO_CHORUS_DELAY_ASSERT_SVH
`define STEREO_CHORUS_DELAY_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define SCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCD_ASSERT_IMP(lbl, ante, cons, msg)
`define SCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/scd_pkg.sv =====
// ---------------------------------------------------------------------------
// Stereo chorus delay: package
// Widths, register indexes, reset values, sequencer types and the fixed
// point helpers shared by the chorus modules.
// ---------------------------------------------------------------------------
package scd_pkg;

  // Default delay line length in samples.
  localparam int DELAY_DEPTH_DEF = 4096;

  // Fixed data formats.
  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int TBL_W           = $clog2(SINE_TABLE_SIZE);
  localparam int SIN_FRAC_W      = TBL_W - 2;
  localparam int SIN_W           = 16;

  // Datapath widths: Q16 polynomial terms, multiplier operands and sums.
  localparam int X_W    = 17;
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 38;
  localparam int U_W    = 17;

  // Configuration register widths.
  localparam int BASE_W     = 12;
  localparam int DEPTH_W    = 12;
  localparam int STEP_W     = 24;
  localparam int MIX_W      = 16;
  localparam int FB_W       = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = CFG_IDX_W'(4);

  // Register reset values.
  localparam logic [BASE_W-1:0]  BASE_DELAY_RST    = BASE_W'(336);
  localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST     = DEPTH_W'(240);
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST    = STEP_W'(140);
  localparam logic [MIX_W-1:0]   MIX_LEVEL_RST     = MIX_W'(22938);
  localparam logic [FB_W-1:0]    FEEDBACK_GAIN_RST = FB_W'(6554);

  // One third of an LFO cycle, rounded down.
  localparam logic [PHASE_BITS-1:0] PH_THIRD =
    PHASE_BITS'((64'd1 << PHASE_BITS) / 64'd3);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // Top level sequencer.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LFO,
    ST_READ,
    ST_FB,
    ST_DRY,
    ST_WET,
    ST_WRITE,
    ST_OUT
  } scd_state_t;

  // Sine and tap delay sequencer.
  typedef enum logic [2:0] {
    SS_IDLE,
    SS_LOAD,
    SS_SQ,
    SS_T1,
    SS_T2,
    SS_Y,
    SS_DLY
  } scd_sine_st_t;

  // Which product the channel unit forms this cycle.
  typedef enum logic [1:0] {
    MS_FB,
    MS_DRY,
    MS_WET
  } scd_mul_sel_t;

  typedef struct packed {
    logic         en;
    scd_mul_sel_t sel;
  } scd_chan_ctl_t;

  // Q1.15 rounding, half up: floor((p + 16384) / 32768).
  function automatic logic signed [ACC_W-1:0] rnd_q15(input logic signed [ACC_W-1:0] p);
    return (p + $signed(ACC_W'(16384))) >>> 15;
  endfunction

  // Saturate a wide value to a signed sample.
  function automatic smp_t sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed(ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/scd_ifs.sv =====
// ---------------------------------------------------------------------------
// Stereo chorus delay: channel interfaces
// Valid/ready channels for the sample input, the mixed output and the
// configuration writes.
// ---------------------------------------------------------------------------

// Input word: one stereo sample pair.
interface scd_in_if import scd_pkg::*; ();
  logic valid;
  logic ready;
  smp_t left_in;
  smp_t right_in;
  modport source(output valid, left_in, right_in, input ready);
  modport sink(input valid, left_in, right_in, output ready);
endinterface

// Output word: one mixed stereo sample pair.
interface scd_out_if import scd_pkg::*; ();
  logic valid;
  logic ready;
  smp_t left_out;
  smp_t right_out;
  modport source(output valid, left_out, right_out, input ready);
  modport sink(input valid, left_out, right_out, output ready);
endinterface

// Configuration word: register index and write data.
interface scd_cfg_if import scd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/scd_sine.sv =====
// ---------------------------------------------------------------------------
// Stereo chorus delay: LFO sine and tap delay unit
// Evaluates the Q1.15 sine polynomial for the left and right tap phases
// with one shared multiplier, then turns each into a clamped tap delay.
// ---------------------------------------------------------------------------
module scd_sine import scd_pkg::*; #(
  parameter int  DELAY_DEPTH = DELAY_DEPTH_DEF,
  localparam int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [PHASE_BITS-1:0] phase,
  input  logic [BASE_W-1:0]     base_delay,
  input  logic [DEPTH_W-1:0]    mod_depth,
  output logic                  done,
  output logic [AW-1:0]         dly_left,
  output logic [AW-1:0]         dly_right
);

  scd_sine_st_t state_r, state_nxt;
  logic         tap_r, tap_nxt;

  logic [X_W-1:0]              x_r;
  logic                        neg_r;
  logic [X_W-1:0]              x2_r;
  logic [X_W-1:0]              t_r;
  logic signed [SIN_W-1:0]     s_r;
  logic [AW-1:0]               dly_left_r;
  logic [AW-1:0]               dly_right_r;

  logic [PHASE_BITS-1:0]       tap_phase;
  logic [TBL_W-1:0]            k;
  logic [X_W-1:0]              x_frac;
  logic [X_W-1:0]              x_load;
  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic [X_W-1:0]              ph;
  logic [X_W-1:0]              y_rnd;
  logic [SIN_W-2:0]            sin_mag;
  logic signed [SIN_W-1:0]     s_calc;
  logic signed [ACC_W-1:0]     d_sum;
  logic [U_W-1:0]              u;
  logic [AW-1:0]               dly_calc;

  // Sequencer: six steps per tap, left tap first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      tap_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    done      = 1'b0;
    case (state_r)
      SS_IDLE: begin
        if (start) begin
          state_nxt = SS_LOAD;
          tap_nxt   = 1'b0;
        end
      end
      SS_LOAD: state_nxt = SS_SQ;
      SS_SQ:   state_nxt = SS_T1;
      SS_T1:   state_nxt = SS_T2;
      SS_T2:   state_nxt = SS_Y;
      SS_Y:    state_nxt = SS_DLY;
      SS_DLY: begin
        if (tap_r) begin
          state_nxt = SS_IDLE;
          done      = 1'b1;
        end else begin
          state_nxt = SS_LOAD;
          tap_nxt   = 1'b1;
        end
      end
      default: state_nxt = SS_IDLE;
    endcase
  end

  // Table index and quadrant of the current tap; odd quadrants run backwards.
  always_comb begin
    tap_phase = tap_r ? tap_phase_sum(phase) : phase;
    k         = tap_phase[PHASE_BITS-1 -: TBL_W];
    x_frac    = X_W'({k[SIN_FRAC_W-1:0], {(16 - SIN_FRAC_W){1'b0}}});
    x_load    = k[TBL_W-2] ? (X_W'(65536) - x_frac) : x_frac;
  end

  function automatic logic [PHASE_BITS-1:0] tap_phase_sum(input logic [PHASE_BITS-1:0] p);
    return p + PH_THIRD;
  endfunction

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      SS_SQ: begin
        mul_a = $signed({1'b0, x_r});
        mul_b = $signed({1'b0, x_r});
      end
      SS_T1: begin
        mul_a = $signed(MUL_W'(4640));
        mul_b = $signed({1'b0, x2_r});
      end
      SS_T2: begin
        mul_a = $signed({1'b0, x2_r});
        mul_b = $signed({1'b0, t_r});
      end
      SS_Y: begin
        mul_a = $signed({1'b0, x_r});
        mul_b = $signed({1'b0, t_r});
      end
      SS_DLY: begin
        mul_a = $signed({{(MUL_W - SIN_W){s_r[SIN_W-1]}}, s_r});
        mul_b = $signed({{(MUL_W - DEPTH_W){1'b0}}, mod_depth});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    ph   = prod[16 +: X_W];
  end

  // Sine value: round to Q1.15, cap, and negate in the lower half cycle.
  always_comb begin
    y_rnd = X_W'(({1'b0, ph} + (X_W + 1)'(1)) >> 1);
    if (y_rnd > X_W'(32767)) begin
      sin_mag = '1;
    end else begin
      sin_mag = y_rnd[SIN_W-2:0];
    end
    s_calc = neg_r ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  end

  // Tap delay: base plus swing, negative gives zero, clamped to the line.
  always_comb begin
    d_sum = $signed({{(ACC_W - BASE_W - 15){1'b0}}, base_delay, 15'b0})
          + $signed({{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod});
    if (d_sum[ACC_W-1]) begin
      u = '0;
    end else begin
      u = d_sum[15 +: U_W];
    end
    if (u > U_W'(DELAY_DEPTH - 1)) begin
      u = U_W'(DELAY_DEPTH - 1);
    end
    dly_calc = u[AW-1:0];
  end

  // Datapath registers, one multiply per step after the load.
  always_ff @(posedge clk) begin
    case (state_r)
      SS_LOAD: begin
        x_r   <= x_load;
        neg_r <= k[TBL_W-1];
      end
      SS_SQ:  x2_r <= ph;
      SS_T1:  t_r  <= X_W'(42047) - ph;
      SS_T2:  t_r  <= X_W'(102944) - ph;
      SS_Y:   s_r  <= s_calc;
      SS_DLY: begin
        if (tap_r) begin
          dly_right_r <= dly_calc;
        end else begin
          dly_left_r <= dly_calc;
        end
      end
      default: ;
    endcase
  end

  assign dly_left  = dly_left_r;
  assign dly_right = dly_right_r;

endmodule

// ===== rtl/scd_store.sv =====
// ---------------------------------------------------------------------------
// Stereo chorus delay: delay line store
// Left and right sample memories with one registered read port each, the
// write position and a wrap flag that makes never-written entries read zero.
// ---------------------------------------------------------------------------
`include "stereo_chorus_delay_assert.svh"

module scd_store import scd_pkg::*; #(
  parameter int  DELAY_DEPTH = DELAY_DEPTH_DEF,
  localparam int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_left,
  input  logic [AW-1:0] rd_addr_right,
  input  logic          wr_en,
  input  smp_t          wr_left,
  input  smp_t          wr_right,
  output smp_t          rd_left,
  output smp_t          rd_right,
  output logic [AW-1:0] wp
);

  smp_t mem_left  [DELAY_DEPTH];
  smp_t mem_right [DELAY_DEPTH];

  smp_t          rd_left_r;
  smp_t          rd_right_r;
  logic          vld_left_r;
  logic          vld_right_r;
  logic [AW-1:0] wp_r;
  logic          full_r;

  // Memory write at the write position, registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_left[wp_r]  <= wr_left;
      mem_right[wp_r] <= wr_right;
    end
    if (rd_en) begin
      rd_left_r  <= mem_left[rd_addr_left];
      rd_right_r <= mem_right[rd_addr_right];
    end
  end

  // Until the position first wraps, only entries below it have been written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_left_r  <= 1'b0;
      vld_right_r <= 1'b0;
    end else if (rd_en) begin
      vld_left_r  <= full_r || (rd_addr_left < wp_r);
      vld_right_r <= full_r || (rd_addr_right < wp_r);
    end
  end

  // Write position and wrap flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (wr_en) begin
      if (wp_r == AW'(DELAY_DEPTH - 1)) begin
        wp_r   <= '0;
        full_r <= 1'b1;
      end else begin
        wp_r <= wp_r + AW'(1);
      end
    end
  end

  assign rd_left  = vld_left_r  ? rd_left_r  : '0;
  assign rd_right = vld_right_r ? rd_right_r : '0;
  assign wp       = wp_r;

  `SCD_ASSERT_NXT(a_full_sticky, full_r, full_r, "wrap flag cleared outside reset")
  `SCD_ASSERT_NXT(a_wp_moves, wr_en, wp_r != $past(wp_r), "write position did not advance")
  `SCD_ASSERT_IMP(a_rd_wr_apart, rd_en, !wr_en, "read and write issued together")

endmodule

// ===== rtl/scd_chan.sv =====
// ---------------------------------------------------------------------------
// Stereo chorus delay: channel arithmetic
// Forms the feedback word for the delay line and the dry/wet mix for one
// channel, one product per step through a single multiplier.
// ---------------------------------------------------------------------------
module scd_chan import scd_pkg::*; (
  input  logic             clk,
  input  scd_chan_ctl_t    ctl,
  input  smp_t             smp_in,
  input  smp_t             delayed,
  input  logic [FB_W-1:0]  feedback_gain,
  input  logic [MIX_W-1:0] mix_level,
  output smp_t             wr_data,
  output smp_t             mix_out
);

  logic signed [ACC_W-1:0]  acc_r;
  smp_t                     fb_val_r;
  smp_t                     mix_r;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  in_ext;

  // Operand selection: feedback, dry weight, wet weight.
  always_comb begin
    case (ctl.sel)
      MS_FB: begin
        mul_a = $signed({{(MUL_W - SAMPLE_BITS){delayed[SAMPLE_BITS-1]}}, delayed});
        mul_b = $signed({{(MUL_W - FB_W){1'b0}}, feedback_gain});
      end
      MS_DRY: begin
        mul_a = $signed({{(MUL_W - SAMPLE_BITS){smp_in[SAMPLE_BITS-1]}}, smp_in});
        mul_b = $signed(MUL_W'(32768)) - $signed({{(MUL_W - MIX_W){1'b0}}, mix_level});
      end
      MS_WET: begin
        mul_a = $signed({{(MUL_W - SAMPLE_BITS){delayed[SAMPLE_BITS-1]}}, delayed});
        mul_b = $signed({{(MUL_W - MIX_W){1'b0}}, mix_level});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = mul_a * mul_b;
    prod_ext = $signed({{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod});
    in_ext   = $signed({{(ACC_W - SAMPLE_BITS){smp_in[SAMPLE_BITS-1]}}, smp_in});
  end

  // Result registers; the dry product waits in the accumulator for the wet one.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      case (ctl.sel)
        MS_FB:   fb_val_r <= sat_smp(in_ext + rnd_q15(prod_ext));
        MS_DRY:  acc_r    <= prod_ext;
        MS_WET:  mix_r    <= sat_smp(rnd_q15(acc_r + prod_ext));
        default: ;
      endcase
    end
  end

  assign wr_data = fb_val_r;
  assign mix_out = mix_r;

endmodule

// ===== rtl/stereo_chorus_delay.sv =====
// ---------------------------------------------------------------------------
// Stereo chorus delay
// Each input word is one stereo sample pair and gives one mixed output word.
// The block handles one word at a time: it accepts the word, starts the
// LFO, runs the sine unit (six steps per tap on its single multiplier, left
// then right), then reads the delay lines, forms three channel products,
// writes back and loads the output, waiting there while the output register
// is full and not taken. A new word is accepted while the previous result
// still waits in the output register. The delay lines need no clearing after
// reset: entries not yet written read as zero. Configuration writes are
// taken at any time and should only be made while no word is in flight.
// ---------------------------------------------------------------------------
`include "stereo_chorus_delay_assert.svh"

module stereo_chorus_delay import scd_pkg::*; #(
  parameter int  DELAY_DEPTH = DELAY_DEPTH_DEF,
  localparam int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic      clk,
  input  logic      rst_n,
  scd_in_if.sink    in_chan,
  scd_out_if.source out_chan,
  scd_cfg_if.sink   cfg_chan
);

  scd_state_t state_r, state_nxt;

  logic [BASE_W-1:0]     base_delay_r;
  logic [DEPTH_W-1:0]    mod_depth_r;
  logic [STEP_W-1:0]     phase_step_r;
  logic [MIX_W-1:0]      mix_level_r;
  logic [FB_W-1:0]       feedback_gain_r;
  logic [PHASE_BITS-1:0] lfo_phase_r;

  smp_t left_in_r;
  smp_t right_in_r;
  smp_t left_out_r;
  smp_t right_out_r;
  logic out_valid_r;

  logic          in_acc;
  logic          cfg_acc;
  logic          sine_start;
  logic          sine_done;
  logic [AW-1:0] dly_left;
  logic [AW-1:0] dly_right;
  logic          rd_en;
  logic          wr_en;
  logic          out_load;
  logic [AW-1:0] wp;
  logic [AW:0]   diff_left;
  logic [AW:0]   diff_right;
  logic [AW-1:0] rd_addr_left;
  logic [AW-1:0] rd_addr_right;
  smp_t          rd_left;
  smp_t          rd_right;
  smp_t          wr_left;
  smp_t          wr_right;
  smp_t          mix_left;
  smp_t          mix_right;
  scd_chan_ctl_t chan_ctl;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r    <= BASE_DELAY_RST;
      mod_depth_r     <= MOD_DEPTH_RST;
      phase_step_r    <= PHASE_STEP_RST;
      mix_level_r     <= MIX_LEVEL_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
    end else if (cfg_acc) begin
      case (cfg_chan.index)
        REG_BASE_DELAY:    base_delay_r    <= cfg_chan.data[BASE_W-1:0];
        REG_MOD_DEPTH:     mod_depth_r     <= cfg_chan.data[DEPTH_W-1:0];
        REG_PHASE_STEP:    phase_step_r    <= cfg_chan.data[STEP_W-1:0];
        REG_MIX_LEVEL:     mix_level_r     <= cfg_chan.data[MIX_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_chan.data[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // LFO phase advances as each word is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfo_phase_r <= '0;
    end else if (in_acc) begin
      lfo_phase_r <= lfo_phase_r + PHASE_BITS'(phase_step_r);
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_in_r  <= in_chan.left_in;
      right_in_r <= in_chan.right_in;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    sine_start     = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    out_load       = 1'b0;
    chan_ctl.en    = 1'b0;
    chan_ctl.sel   = MS_FB;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        sine_start = 1'b1;
        state_nxt  = ST_LFO;
      end
      ST_LFO: begin
        if (sine_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        chan_ctl.en  = 1'b1;
        chan_ctl.sel = MS_FB;
        state_nxt    = ST_DRY;
      end
      ST_DRY: begin
        chan_ctl.en  = 1'b1;
        chan_ctl.sel = MS_DRY;
        state_nxt    = ST_WET;
      end
      ST_WET: begin
        chan_ctl.en  = 1'b1;
        chan_ctl.sel = MS_WET;
        state_nxt    = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en     = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // LFO sine and tap delays.
  scd_sine #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_sine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (sine_start),
    .phase      (lfo_phase_r),
    .base_delay (base_delay_r),
    .mod_depth  (mod_depth_r),
    .done       (sine_done),
    .dly_left   (dly_left),
    .dly_right  (dly_right)
  );

  // Read positions behind the write position, wrapped around the line.
  always_comb begin
    diff_left  = {1'b0, wp} - {1'b0, dly_left};
    diff_right = {1'b0, wp} - {1'b0, dly_right};
    rd_addr_left  = diff_left[AW] ? AW'(diff_left + (AW + 1)'(DELAY_DEPTH))
                                  : diff_left[AW-1:0];
    rd_addr_right = diff_right[AW] ? AW'(diff_right + (AW + 1)'(DELAY_DEPTH))
                                   : diff_right[AW-1:0];
  end

  // Delay line memories.
  scd_store #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_en         (rd_en),
    .rd_addr_left  (rd_addr_left),
    .rd_addr_right (rd_addr_right),
    .wr_en         (wr_en),
    .wr_left       (wr_left),
    .wr_right      (wr_right),
    .rd_left       (rd_left),
    .rd_right      (rd_right),
    .wp            (wp)
  );

  // Channel arithmetic, left and right side by side.
  scd_chan u_chan_left (
    .clk           (clk),
    .ctl           (chan_ctl),
    .smp_in        (left_in_r),
    .delayed       (rd_left),
    .feedback_gain (feedback_gain_r),
    .mix_level     (mix_level_r),
    .wr_data       (wr_left),
    .mix_out       (mix_left)
  );

  scd_chan u_chan_right (
    .clk           (clk),
    .ctl           (chan_ctl),
    .smp_in        (right_in_r),
    .delayed       (rd_right),
    .feedback_gain (feedback_gain_r),
    .mix_level     (mix_level_r),
    .wr_data       (wr_right),
    .mix_out       (mix_right)
  );

  // Output register; holds a word until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out_r  <= mix_left;
      right_out_r <= mix_right;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.left_out  = left_out_r;
  assign out_chan.right_out = right_out_r;

  `SCD_ASSERT_IMP(a_done_in_lfo, sine_done, state_r == ST_LFO, "sine unit finished out of turn")
  `SCD_ASSERT_IMP(a_out_from_seq, $rose(out_valid_r), $past(state_r) == ST_OUT, "output word without a finished item")
  `SCD_ASSERT_IMP(a_wr_after_wet, wr_en, $past(state_r) == ST_WET, "delay line written before the mix")

endmodule
